### hdl/miller_rabin_witness_test_macros.svh
// Assertion helpers used by the checker of this block
`ifndef MILLER_RABIN_WITNESS_TEST_MACROS_SVH
`define MILLER_RABIN_WITNESS_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MRW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MRW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mrw_pkg.sv
package mrw_pkg;

  // Datapath word width
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);

  // Verdict codes
  localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
  localparam logic [1:0] VERDICT_PRIME     = 2'd1;
  localparam logic [1:0] VERDICT_LIKELY    = 2'd2;
  localparam logic [1:0] VERDICT_BAD_BASE  = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECOMP,
    ST_POW,
    ST_WAIT_R,
    ST_SQB,
    ST_WAIT_B,
    ST_EVAL,
    ST_SQX,
    ST_WAIT_X
  } mrw_state_t;

  // Modular multiplier step phase
  typedef enum logic {
    PH_DBL,
    PH_ADD
  } mrw_phase_t;

  // Request to the modular multiplier
  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] op_a;
    logic [WORD_BITS-1:0] op_b;
    logic [WORD_BITS-1:0] modulus;
  } mrw_mul_req_t;

  // Response from the modular multiplier
  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] product;
  } mrw_mul_rsp_t;

endpackage

### hdl/miller_rabin_witness_test.sv
// Trivial candidates and a bad witness: the sequencer goes from CHECK straight back to IDLE.
// Otherwise n-1 = 2^s*d is decomposed, then every modular product runs on the shared
// shift-and-add multiplier, with a doubling step per bit plus an add step per set bit.
// One item at a time; busy stays high until the verdict strobe.
// Reset: synchronous, active low; clears the sequencer and the strobe, nothing else.
// The verdict is shown for exactly one cycle; the receiver cannot stall it.
module miller_rabin_witness_test (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mrw_pkg::WORD_BITS-1:0] in_candidate,
  input  logic [mrw_pkg::WORD_BITS-1:0] in_witness,
  output logic                          out_strobe,
  output logic [1:0]                    out_verdict
);

  localparam int WB = mrw_pkg::WORD_BITS;
  localparam int CW = mrw_pkg::CNT_W;

  mrw_pkg::mrw_state_t state_r, state_nxt;

  logic [WB-1:0] n_r, n_nxt;
  logic [WB-1:0] a_r, a_nxt;
  logic [WB-1:0] d_r, d_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [WB-1:0] x_r, x_nxt;
  logic [WB-1:0] b_r, b_nxt;
  logic [1:0]    verdict_r, verdict_nxt;
  logic          strobe_r, strobe_nxt;
  logic [1:0]    fin_code;

  logic [WB-1:0] nm1;
  logic          is_trivial;
  logic          bad_base;

  mrw_pkg::mrw_mul_req_t mul_req;
  mrw_pkg::mrw_mul_rsp_t mul_rsp;

  mrw_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Candidate screening
  always_comb begin
    nm1        = n_r - WB'(1);
    is_trivial = !n_r[0] || (n_r == WB'(3)) || (n_r == WB'(1));
    bad_base   = (a_r < WB'(2)) || (a_r > (n_r - WB'(2)));
    if (!n_r[0]) begin
      fin_code = (n_r == WB'(2)) ? mrw_pkg::VERDICT_PRIME : mrw_pkg::VERDICT_COMPOSITE;
    end else if (n_r == WB'(3)) begin
      fin_code = mrw_pkg::VERDICT_PRIME;
    end else if (n_r == WB'(1)) begin
      fin_code = mrw_pkg::VERDICT_COMPOSITE;
    end else begin
      fin_code = mrw_pkg::VERDICT_BAD_BASE;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrw_pkg::ST_IDLE:   if (start) state_nxt = mrw_pkg::ST_CHECK;
      mrw_pkg::ST_CHECK: begin
        if (is_trivial || bad_base) state_nxt = mrw_pkg::ST_IDLE;
        else                        state_nxt = mrw_pkg::ST_DECOMP;
      end
      mrw_pkg::ST_DECOMP: if (d_r[0]) state_nxt = mrw_pkg::ST_POW;
      mrw_pkg::ST_POW: begin
        if (d_r == '0)  state_nxt = mrw_pkg::ST_EVAL;
        else if (d_r[0]) state_nxt = mrw_pkg::ST_WAIT_R;
        else             state_nxt = mrw_pkg::ST_WAIT_B;
      end
      mrw_pkg::ST_WAIT_R: if (mul_rsp.done) state_nxt = mrw_pkg::ST_SQB;
      mrw_pkg::ST_SQB:    state_nxt = mrw_pkg::ST_WAIT_B;
      mrw_pkg::ST_WAIT_B: if (mul_rsp.done) state_nxt = mrw_pkg::ST_POW;
      mrw_pkg::ST_EVAL: begin
        if (x_r == WB'(1) || x_r == nm1 || s_r == CW'(1)) state_nxt = mrw_pkg::ST_IDLE;
        else                                             state_nxt = mrw_pkg::ST_SQX;
      end
      mrw_pkg::ST_SQX:    state_nxt = mrw_pkg::ST_WAIT_X;
      mrw_pkg::ST_WAIT_X: begin
        if (mul_rsp.done) begin
          if (mul_rsp.product == nm1 || mul_rsp.product == WB'(1) || rem_r == CW'(1)) begin
            state_nxt = mrw_pkg::ST_IDLE;
          end else begin
            state_nxt = mrw_pkg::ST_SQX;
          end
        end
      end
      default: state_nxt = mrw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    n_nxt       = n_r;
    a_nxt       = a_r;
    d_nxt       = d_r;
    s_nxt       = s_r;
    rem_nxt     = rem_r;
    x_nxt       = x_r;
    b_nxt       = b_r;
    verdict_nxt = verdict_r;
    mul_req.start   = 1'b0;
    mul_req.op_a    = x_r;
    mul_req.op_b    = b_r;
    mul_req.modulus = n_r;
    case (state_r)
      mrw_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt = in_candidate;
          a_nxt = in_witness;
        end
      end
      mrw_pkg::ST_CHECK: begin
        verdict_nxt = fin_code;
        d_nxt       = nm1;
        s_nxt       = '0;
        x_nxt       = WB'(1);
        b_nxt       = a_r;
      end
      mrw_pkg::ST_DECOMP: begin
        if (!d_r[0]) begin
          d_nxt = {1'b0, d_r[WB-1:1]};
          s_nxt = s_r + CW'(1);
        end
      end
      mrw_pkg::ST_POW: begin
        // odd exponent bit: x*b, else straight to squaring b
        if (d_r != '0) begin
          mul_req.start = 1'b1;
          mul_req.op_a  = d_r[0] ? x_r : b_r;
        end
      end
      mrw_pkg::ST_WAIT_R: if (mul_rsp.done) x_nxt = mul_rsp.product;
      mrw_pkg::ST_SQB: begin
        mul_req.start = 1'b1;
        mul_req.op_a  = b_r;
      end
      mrw_pkg::ST_WAIT_B: begin
        if (mul_rsp.done) begin
          b_nxt = mul_rsp.product;
          d_nxt = {1'b0, d_r[WB-1:1]};
        end
      end
      mrw_pkg::ST_EVAL: begin
        rem_nxt = s_r - CW'(1);
        if (x_r == WB'(1) || x_r == nm1) verdict_nxt = mrw_pkg::VERDICT_LIKELY;
        else                             verdict_nxt = mrw_pkg::VERDICT_COMPOSITE;
      end
      mrw_pkg::ST_SQX: begin
        mul_req.start = 1'b1;
        mul_req.op_b  = x_r;
      end
      mrw_pkg::ST_WAIT_X: begin
        if (mul_rsp.done) begin
          x_nxt   = mul_rsp.product;
          rem_nxt = rem_r - CW'(1);
          if (mul_rsp.product == nm1) verdict_nxt = mrw_pkg::VERDICT_LIKELY;
          else                        verdict_nxt = mrw_pkg::VERDICT_COMPOSITE;
        end
      end
      default: ;
    endcase
    strobe_nxt = (state_r != mrw_pkg::ST_IDLE) && (state_nxt == mrw_pkg::ST_IDLE);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mrw_pkg::ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    a_r       <= a_nxt;
    d_r       <= d_nxt;
    s_r       <= s_nxt;
    rem_r     <= rem_nxt;
    x_r       <= x_nxt;
    b_r       <= b_nxt;
    verdict_r <= verdict_nxt;
  end

  assign busy        = (state_r != mrw_pkg::ST_IDLE);
  assign out_strobe  = strobe_r;
  assign out_verdict = verdict_r;

endmodule

### hdl/mrw_mulmod.sv
// Shift-and-add modular multiplier: one modular add per cycle.
// Each bit of op_b costs a doubling step, plus an add step when the bit is set.
module mrw_mulmod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrw_pkg::mrw_mul_req_t req,
  output mrw_pkg::mrw_mul_rsp_t rsp
);

  localparam int WB = mrw_pkg::WORD_BITS;
  localparam int CW = mrw_pkg::CNT_W;

  logic                busy_r;
  logic                done_r;
  mrw_pkg::mrw_phase_t phase_r;
  logic [CW-1:0]       cnt_r;
  logic [WB-1:0]       acc_r;
  logic [WB-1:0]       x_r;
  logic [WB-1:0]       y_r;
  logic [WB-1:0]       m_r;

  logic [WB-1:0] opnd;
  logic [WB:0]   sum;
  logic [WB:0]   red;
  logic [WB-1:0] step_res;
  logic          last_bit;
  logic          go_add;

  // Shared modular adder: acc + (acc or x), one subtract of m at most
  always_comb begin
    opnd     = (phase_r == mrw_pkg::PH_ADD) ? x_r : acc_r;
    sum      = {1'b0, acc_r} + {1'b0, opnd};
    red      = sum - {1'b0, m_r};
    step_res = (sum >= {1'b0, m_r}) ? red[WB-1:0] : sum[WB-1:0];
    go_add   = (phase_r == mrw_pkg::PH_DBL) && y_r[WB-1];
    last_bit = (cnt_r == '0);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= mrw_pkg::PH_DBL;
      cnt_r   <= '0;
    end else begin
      if (req.start) begin
        busy_r  <= 1'b1;
        done_r  <= 1'b0;
        phase_r <= mrw_pkg::PH_DBL;
        cnt_r   <= CW'(WB - 1);
      end else if (busy_r) begin
        if (go_add) begin
          phase_r <= mrw_pkg::PH_ADD;
          done_r  <= 1'b0;
        end else begin
          phase_r <= mrw_pkg::PH_DBL;
          if (last_bit) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt_r  <= cnt_r - CW'(1);
            done_r <= 1'b0;
          end
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      x_r   <= req.op_a;
      y_r   <= req.op_b;
      m_r   <= req.modulus;
    end else if (busy_r) begin
      acc_r <= step_res;
      if (!go_add && !last_bit) begin
        y_r <= {y_r[WB-2:0], 1'b0};
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

### hdl/mrw_checker.sv
`include "miller_rabin_witness_test_macros.svh"

// Port-level checks of the witness test
module mrw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [mrw_pkg::WORD_BITS-1:0] in_candidate,
  input logic                          out_strobe,
  input logic [1:0]                    out_verdict
);

  localparam int WB = mrw_pkg::WORD_BITS;

  logic [1:0] even_verdict;

  // verdict an even candidate must get
  assign even_verdict = (in_candidate == WB'(2)) ? mrw_pkg::VERDICT_PRIME
                                                 : mrw_pkg::VERDICT_COMPOSITE;

  // accepted beat keeps the block busy next cycle
  `MRW_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")

  // verdict is a single-cycle pulse
  `MRW_ASSERT_NXT(a_strobe_pulse, clk, rst_n, out_strobe, !out_strobe, "strobe too long")

  // busy only drops together with a verdict
  `MRW_ASSERT_IMP(a_fall_result, clk, rst_n, $fell(busy), out_strobe, "busy fell without verdict")

  // even candidates resolve on the trivial path: 2 is prime, the rest composite
  `MRW_ASSERT_IMP(a_even_fast, clk, rst_n, start && !busy && !in_candidate[0], ##2 (out_strobe && (out_verdict == $past(even_verdict, 2))), "even candidate verdict wrong")

endmodule

bind miller_rabin_witness_test mrw_checker u_mrw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_candidate (in_candidate),
  .out_strobe   (out_strobe),
  .out_verdict  (out_verdict)
);
